// ===== rtl/tbh_pkg.sv =====
package tbh_pkg;

  localparam int unsigned CodesPerWord = 16;
  localparam int unsigned NumCodes     = 4;
  localparam int unsigned CodeW        = 2;
  localparam int unsigned WordW        = 32;
  localparam int unsigned WpbW         = 17;
  localparam int unsigned CountW       = 21;
  localparam int unsigned ShareW       = 14;
  localparam int unsigned BlockW       = 32;
  localparam int unsigned IncW         = 5;
  localparam int unsigned ScaleW       = 15;
  localparam int unsigned ProdW        = CountW + ScaleW;
  localparam int unsigned NumW         = 35;
  localparam int unsigned RemW         = 21;
  localparam int unsigned DenW         = 22;
  localparam int unsigned StepW        = 4;

  localparam logic [WpbW-1:0]   WpbReset   = 17'd1024;
  localparam logic [WpbW-1:0]   MaxWords   = 17'd65536;
  localparam logic [ScaleW-1:0] ShareScale = 15'd20000;

  typedef logic [CountW-1:0] count_t;
  typedef logic [ShareW-1:0] share_t;

  typedef struct packed {
    logic             accept;
    logic             load;
    logic             step;
    logic             last;
    logic [CodeW-1:0] code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic blk_end;
  } ctrl_sts_t;

endpackage

// ===== rtl/tbh_if.sv =====
interface tbh_sample_if import tbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] sample_word;

  modport source (output valid, output sample_word, input ready);
  modport sink   (input valid, input sample_word, output ready);
endinterface

interface tbh_result_if import tbh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BlockW-1:0] block_number;
  count_t            count_code_zero;
  count_t            count_code_one;
  count_t            count_code_two;
  count_t            count_code_three;
  share_t            share_code_zero;
  share_t            share_code_one;
  share_t            share_code_two;
  share_t            share_code_three;

  modport source (
    output valid, input ready, output block_number,
    output count_code_zero, output count_code_one,
    output count_code_two, output count_code_three,
    output share_code_zero, output share_code_one,
    output share_code_two, output share_code_three
  );
  modport sink (
    input valid, output ready, input block_number,
    input count_code_zero, input count_code_one,
    input count_code_two, input count_code_three,
    input share_code_zero, input share_code_one,
    input share_code_two, input share_code_three
  );
endinterface

interface tbh_cfg_if import tbh_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [WpbW-1:0] words_per_block;

  modport source (output valid, output words_per_block, input ready);
  modport sink   (input valid, input words_per_block, output ready);
endinterface

// ===== rtl/tbh_datapath.sv =====
module tbh_datapath import tbh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output ctrl_sts_t         sts_o,
  input  logic [WordW-1:0]  sample_word_i,
  input  logic              cfg_we_i,
  input  logic [WpbW-1:0]   cfg_wpb_i,
  output logic [BlockW-1:0] block_number_o,
  output count_t            count_o [NumCodes],
  output share_t            share_o [NumCodes]
);

  logic [WpbW-1:0]   wpb_q;
  logic [WpbW-1:0]   seen_q;
  logic [BlockW-1:0] block_q;
  count_t            tally_q [NumCodes];
  count_t            cnt_q   [NumCodes];
  share_t            share_q [NumCodes];
  logic [BlockW-1:0] blk_out_q;
  logic [WpbW-1:0]   total_q;
  logic [RemW-1:0]   rem_q;
  logic [ShareW-1:0] lo_q;
  logic [ShareW-1:0] quo_q;

  logic [IncW-1:0]   inc [NumCodes];
  logic [WpbW-1:0]   eff_len;
  logic [WpbW-1:0]   taken;
  logic              blk_end;
  logic [ProdW-1:0]  num_full;
  logic [DenW-1:0]   den;
  logic [DenW-1:0]   trial;
  logic              ge;
  logic [DenW-1:0]   diff;
  logic [RemW-1:0]   rem_d;
  logic [ShareW-1:0] quo_d;

  // per-code occurrence count within one word
  always_comb begin
    for (int c = 0; c < NumCodes; c++) begin
      inc[c] = '0;
      for (int k = 0; k < CodesPerWord; k++) begin
        if (sample_word_i[CodeW*k +: CodeW] == CodeW'(c)) begin
          inc[c] = inc[c] + IncW'(1);
        end
      end
    end
  end

  always_comb begin
    if (wpb_q == '0) begin
      eff_len = WpbW'(1);
    end else if (wpb_q > MaxWords) begin
      eff_len = MaxWords;
    end else begin
      eff_len = wpb_q;
    end
  end

  assign taken         = seen_q + WpbW'(1);
  assign blk_end       = taken >= eff_len;
  assign sts_o.blk_end = blk_end;

  // numerator 20000*count + total, total = 16*words
  assign num_full = (ProdW'(cnt_q[cmd_i.code]) * ProdW'(ShareScale))
                  + ProdW'({total_q, 4'b0000});
  assign den      = {total_q, 5'b00000};
  assign trial    = {rem_q, lo_q[ShareW-1]};
  assign ge       = trial >= den;
  assign diff     = trial - den;
  assign rem_d    = ge ? diff[RemW-1:0] : trial[RemW-1:0];
  assign quo_d    = {quo_q[ShareW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpb_q   <= WpbReset;
      seen_q  <= '0;
      block_q <= '0;
      for (int c = 0; c < NumCodes; c++) begin
        tally_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        wpb_q <= cfg_wpb_i;
      end
      if (cmd_i.accept) begin
        if (blk_end) begin
          seen_q  <= '0;
          block_q <= block_q + BlockW'(1);
          for (int c = 0; c < NumCodes; c++) begin
            tally_q[c] <= '0;
          end
        end else begin
          seen_q <= taken;
          for (int c = 0; c < NumCodes; c++) begin
            tally_q[c] <= tally_q[c] + CountW'(inc[c]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && blk_end) begin
      blk_out_q <= block_q;
      total_q   <= taken;
      for (int c = 0; c < NumCodes; c++) begin
        cnt_q[c] <= tally_q[c] + CountW'(inc[c]);
      end
    end
    if (cmd_i.load) begin
      rem_q <= num_full[NumW-1:ShareW];
      lo_q  <= num_full[ShareW-1:0];
      quo_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[ShareW-2:0], 1'b0};
      quo_q <= quo_d;
      if (cmd_i.last) begin
        share_q[cmd_i.code] <= quo_d;
      end
    end
  end

  assign block_number_o = blk_out_q;
  assign count_o        = cnt_q;
  assign share_o        = share_q;

endmodule

// ===== rtl/tbh_ctrl.sv =====
module tbh_ctrl import tbh_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  ctrl_sts_t sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_e;

  state_e           state_q;
  logic             ready_q;
  logic             valid_q;
  logic [StepW-1:0] step_q;
  logic [CodeW-1:0] code_q;
  logic             accept;
  logic             step_last;
  logic             code_last;

  assign accept    = in_valid_i && ready_q;
  assign step_last = step_q == StepW'(ShareW - 1);
  assign code_last = code_q == CodeW'(NumCodes - 1);

  assign cmd_o.accept = accept;
  assign cmd_o.load   = state_q == ST_LOAD;
  assign cmd_o.step   = state_q == ST_DIV;
  assign cmd_o.last   = step_last;
  assign cmd_o.code   = code_q;

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
      step_q  <= '0;
      code_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept && sts_i.blk_end) begin
            ready_q <= 1'b0;
            code_q  <= '0;
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          step_q  <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + StepW'(1);
          if (step_last) begin
            if (code_last) begin
              valid_q <= 1'b1;
              state_q <= ST_OUT;
            end else begin
              code_q  <= code_q + CodeW'(1);
              state_q <= ST_LOAD;
            end
          end
        end
        ST_OUT: begin
          if (out_ready_i) begin
            valid_q <= 1'b0;
            ready_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/two_bit_sample_state_histogram.sv =====
// channel   dir  payload                                  transfer
// sample_i  in   sample_word[31:0]                        valid & ready
// result_o  out  block_number, count_code_*, share_code_* valid & ready
// cfg_i     in   words_per_block[16:0]                    valid & ready (ready always high)
//
// a word that does not close a block is counted and leaves sample ready high for the next word
// a closing word ends the block and starts the division of the shares
// one shared 14-step divider works out the four shares, a load and 14 steps per code
// the result then holds until taken; no sample is taken meanwhile
// reset: running counts and block counter zero, words_per_block 1024; result registers are not reset
module two_bit_sample_state_histogram import tbh_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbh_sample_if.sink    sample_i,
  tbh_result_if.source  result_o,
  tbh_cfg_if.sink       cfg_i
);

  ctrl_cmd_t         cmd;
  ctrl_sts_t         sts;
  logic [BlockW-1:0] block_number;
  count_t            count [NumCodes];
  share_t            share [NumCodes];

  assign cfg_i.ready = 1'b1;

  tbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tbh_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_word_i  (sample_i.sample_word),
    .cfg_we_i       (cfg_i.valid),
    .cfg_wpb_i      (cfg_i.words_per_block),
    .block_number_o (block_number),
    .count_o        (count),
    .share_o        (share)
  );

  assign result_o.block_number     = block_number;
  assign result_o.count_code_zero  = count[0];
  assign result_o.count_code_one   = count[1];
  assign result_o.count_code_two   = count[2];
  assign result_o.count_code_three = count[3];
  assign result_o.share_code_zero  = share[0];
  assign result_o.share_code_one   = share[1];
  assign result_o.share_code_two   = share[2];
  assign result_o.share_code_three = share[3];

endmodule
